FILE: rtl/two_level_priority_rr_scheduler_assert.svh
// Assertion macros for the two-level priority round-robin scheduler.
`ifndef TWO_LEVEL_PRIORITY_RR_SCHEDULER_ASSERT_SVH
`define TWO_LEVEL_PRIORITY_RR_SCHEDULER_ASSERT_SVH
// Property a must imply b at the same edge.
`define TLPS_ASSERT_IMPL(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error("assertion failed");
// Property a must imply b at the next edge.
`define TLPS_ASSERT_NEXT(label, a, b) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error("assertion failed");
`endif

FILE: rtl/tlps_pkg.sv
// Package with task record, status codes and shared constants of the scheduler.
package tlps_pkg;
   typedef struct packed {
      logic [15:0] left;
      logic [7:0]  prio;
      logic [7:0]  id;
   } task_type;

   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_RAN    = 2'd2;
   localparam logic [1:0] ST_IDLE   = 2'd3;

   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [7:0] QUANTUM_RESET = 8'd4;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] running_id;
      logic       task_finished;
      logic       slice_expired;
      logic       preempted;
   } result_type;
endpackage

FILE: rtl/tlps_store.sv
// Priority store: task memory with valid bits and a registered read port.
module tlps_store
   import tlps_pkg::*;
#(
   parameter int MAX_TASKS = 16,
   parameter int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            wr_en,
   input  logic [IW-1:0]   wr_idx,
   input  task_type        wr_task,
   input  logic            clr_en,
   input  logic [IW-1:0]   clr_idx,
   input  logic            rd_en,
   input  logic [IW-1:0]   rd_idx,
   output task_type        rd_task,
   output logic [MAX_TASKS-1:0] valid
);
   task_type mem [MAX_TASKS];
   logic [MAX_TASKS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_task;
      end
      if (rd_en) begin
         rd_task <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (wr_en) valid_ff[wr_idx] <= 1'b1;
         if (clr_en) valid_ff[clr_idx] <= 1'b0;
      end
   end

   assign valid = valid_ff;
endmodule

FILE: rtl/tlps_fifo.sv
// Round-robin FIFO memory with head and count.
module tlps_fifo
   import tlps_pkg::*;
#(
   parameter int MAX_TASKS = 16,
   parameter int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
   parameter int CW = $clog2(MAX_TASKS + 1)
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type push_task,
   input  logic     pop_rd,
   output task_type head_task,
   output logic [CW-1:0] count
);
   task_type mem [MAX_TASKS];
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW:0]   tail_sum;
   logic          do_push;

   assign do_push  = push && (count_ff < CW'(MAX_TASKS));
   assign tail_sum = {1'b0, head_ff} + (IW+1)'(count_ff);

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[IW'(tail_sum % (IW+1)'(MAX_TASKS))] <= push_task;
      end
      head_task <= mem[head_ff];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (pop_rd) begin
         head_in  = IW'(({1'b0, head_ff} + 1'b1) % (IW+1)'(MAX_TASKS));
         count_in = count_in - 1'b1;
      end
      if (do_push) count_in = count_in + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign count = count_ff;
endmodule

FILE: rtl/two_level_priority_rr_scheduler.sv
// Top level of the two-level priority / round-robin task scheduler.
// Usage:
// - req_ channel carries one transaction per arrival or tick; tuser is op.
// - rsp_ channel returns exactly one result transaction per request.
// - csr_wr_en/csr_wr_data set quantum_length; write only while idle.
// Sequence: an arrival result follows the free slot search via valid bits
// plus the memory write (S_ARR, S_OUT); a tick result follows the
// sequential scan of the priority store memory, one entry a cycle,
// followed by the best entry read, the FIFO head decision and the task
// update (S_SCAN, S_RDB, S_LAST, S_DEC, S_RUN, S_OUT).
// One request is in flight at a time; req_tready rises again the cycle after
// the result transaction.
// Reset: store empty, FIFO empty, CPU idle, quantum 4; no clearing pass.
// A stalled rsp_tready holds the result; no new request is taken until
// the output register is free.
module two_level_priority_rr_scheduler
   import tlps_pkg::*;
#(
   parameter int MAX_TASKS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // task_id[7:0], task_priority[15:8], burst_length[31:16]
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[1:0], running_id[9:2], task_finished[10],
                                    // slice_expired[11], preempted[12], zero[15:13]
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   `include "two_level_priority_rr_scheduler_assert.svh"

   localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ARR   = 4'd1;
   localparam logic [3:0] S_SCAN  = 4'd2;
   localparam logic [3:0] S_LAST  = 4'd3;
   localparam logic [3:0] S_RDB   = 4'd4;
   localparam logic [3:0] S_DEC   = 4'd5;
   localparam logic [3:0] S_RUN   = 4'd6;
   localparam logic [3:0] S_OUT   = 4'd7;

   logic [3:0]  state_ff, state_in;
   logic [7:0]  quantum_ff;
   logic [31:0] req_ff;
   logic [IW:0] scan_ff, scan_in;
   logic        best_ok_ff;
   logic [IW-1:0] best_ff;
   logic [15:0] best_key_ff;
   logic        rd_pend_ff;
   logic [IW-1:0] rd_pend_idx_ff;
   task_type    cur_ff;
   logic        busy_ff, from_pri_ff, from_rr_ff;
   logic [7:0]  slice_ff;
   logic [CW-1:0] pcount_ff;
   result_type  res_ff;
   logic        out_valid_ff;

   logic            st_wr, st_clr, st_rd;
   logic [IW-1:0]   st_wr_idx, st_clr_idx, st_rd_idx;
   task_type        st_wr_task, st_rd_task;
   logic [MAX_TASKS-1:0] st_valid;
   logic            ff_push, ff_pop;
   task_type        ff_push_task, ff_head;
   logic [CW-1:0]   ff_count;

   logic [IW-1:0] free_idx;
   logic          free_ok;

   tlps_store #(.MAX_TASKS(MAX_TASKS)) u_store (
      .clock(clock), .reset(reset),
      .wr_en(st_wr), .wr_idx(st_wr_idx), .wr_task(st_wr_task),
      .clr_en(st_clr), .clr_idx(st_clr_idx),
      .rd_en(st_rd), .rd_idx(st_rd_idx), .rd_task(st_rd_task),
      .valid(st_valid)
   );

   tlps_fifo #(.MAX_TASKS(MAX_TASKS)) u_fifo (
      .clock(clock), .reset(reset),
      .push(ff_push), .push_task(ff_push_task),
      .pop_rd(ff_pop), .head_task(ff_head), .count(ff_count)
   );

   always_comb begin
      free_ok  = 1'b0;
      free_idx = '0;
      for (int i = MAX_TASKS - 1; i >= 0; i--) begin
         if (!st_valid[i]) begin
            free_ok  = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, res_ff.preempted, res_ff.slice_expired,
                        res_ff.task_finished, res_ff.running_id, res_ff.status};

   // store read at scan address or chosen best slot
   assign st_rd     = (state_ff == S_SCAN) || (state_ff == S_LAST);
   assign st_rd_idx = (state_ff == S_LAST) ? best_ff : scan_ff[IW-1:0];

   // decision signals, valid in S_DEC (st_rd_task = best entry, ff_head = FIFO head)
   logic take_pri, take_rr, preempt;
   always_comb begin
      take_pri = 1'b0;
      take_rr  = 1'b0;
      preempt  = 1'b0;
      if (!busy_ff) begin
         take_pri = best_ok_ff;
         take_rr  = !best_ok_ff && (ff_count != '0);
      end else if (best_ok_ff) begin
         if (from_pri_ff) preempt = st_rd_task.prio < cur_ff.prio;
         else if (from_rr_ff) preempt = 1'b1;
         take_pri = preempt;
      end
   end

   always_comb begin
      st_wr      = (state_ff == S_ARR) && (req_ff[31:16] != 16'd0) && free_ok;
      st_wr_idx  = free_idx;
      st_wr_task = '{left: req_ff[31:16], prio: req_ff[15:8], id: req_ff[7:0]};
      st_clr     = (state_ff == S_DEC) && take_pri;
      st_clr_idx = best_ff;
      ff_pop     = (state_ff == S_DEC) && take_rr;
      ff_push    = ((state_ff == S_DEC) && preempt) ||
                   ((state_ff == S_RUN) && busy_ff && (cur_ff.left != 16'd1) &&
                    (slice_ff == 8'd1));
      ff_push_task = (state_ff == S_RUN) ?
                     task_type'{left: cur_ff.left - 16'd1, prio: cur_ff.prio,
                                id: cur_ff.id} : cur_ff;
   end

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               state_in = (req_tuser == OP_ARRIVE) ? S_ARR : S_SCAN;
               scan_in  = '0;
            end
         end
         S_ARR: state_in = S_OUT;
         S_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == (IW+1)'(MAX_TASKS - 1)) state_in = S_RDB;
         end
         S_RDB:  state_in = S_LAST;
         S_LAST: state_in = S_DEC;
         S_DEC:  state_in = S_RUN;
         S_RUN:  state_in = S_OUT;
         S_OUT:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // S_RDB exists to let the final scan read land before S_LAST reissues best read
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid && req_tready) begin
         req_ff <= req_tdata;
      end
      if (state_ff == S_IDLE) begin
         best_ok_ff <= 1'b0;
         best_ff    <= '0;
         best_key_ff <= '0;
      end else if (rd_pend_ff && st_valid[rd_pend_idx_ff] &&
                   (state_ff == S_SCAN || state_ff == S_RDB)) begin
         if (!best_ok_ff || {st_rd_task.prio, st_rd_task.id} < best_key_ff) begin
            best_ok_ff  <= 1'b1;
            best_ff     <= rd_pend_idx_ff;
            best_key_ff <= {st_rd_task.prio, st_rd_task.id};
         end
      end
      rd_pend_idx_ff <= scan_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         quantum_ff   <= QUANTUM_RESET;
         busy_ff      <= 1'b0;
         from_pri_ff  <= 1'b0;
         from_rr_ff   <= 1'b0;
         slice_ff     <= QUANTUM_RESET;
         cur_ff       <= '0;
         pcount_ff    <= '0;
         out_valid_ff <= 1'b0;
         res_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         rd_pend_ff <= (state_ff == S_SCAN);
         if (csr_wr_en) quantum_ff <= csr_wr_data;
         if (out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         if (st_wr) pcount_ff <= pcount_ff + 1'b1;
         if (st_clr) pcount_ff <= pcount_ff - 1'b1;
         if (state_ff == S_ARR) begin
            res_ff <= '{status: st_wr ? ST_ACCEPT : ST_REJECT, running_id: 8'd0,
                        task_finished: 1'b0, slice_expired: 1'b0, preempted: 1'b0};
         end
         if (state_ff == S_DEC) begin
            res_ff <= '{status: ST_IDLE, running_id: 8'd0, task_finished: 1'b0,
                        slice_expired: 1'b0, preempted: preempt};
            if (take_pri) begin
               cur_ff      <= st_rd_task;
               busy_ff     <= 1'b1;
               from_pri_ff <= 1'b1;
               from_rr_ff  <= 1'b0;
               slice_ff    <= quantum_ff;
            end else if (take_rr) begin
               cur_ff     <= ff_head;
               busy_ff    <= 1'b1;
               from_rr_ff <= 1'b1;
               slice_ff   <= quantum_ff;
            end
         end
         if (state_ff == S_RUN && busy_ff) begin
            res_ff.status     <= ST_RAN;
            res_ff.running_id <= cur_ff.id;
            cur_ff.left       <= cur_ff.left - 16'd1;
            slice_ff          <= slice_ff - 8'd1;
            if (cur_ff.left == 16'd1) begin
               res_ff.task_finished <= 1'b1;
               busy_ff     <= 1'b0;
               from_pri_ff <= 1'b0;
               from_rr_ff  <= 1'b0;
               slice_ff    <= quantum_ff;
            end else if (slice_ff == 8'd1) begin
               res_ff.slice_expired <= 1'b1;
               busy_ff     <= 1'b0;
               from_pri_ff <= 1'b0;
               from_rr_ff  <= 1'b0;
            end
         end
         if (state_ff == S_OUT) out_valid_ff <= 1'b1;
      end
   end

   `TLPS_ASSERT_IMPL(a_cnt_match, 1'b1, pcount_ff == CW'($countones(st_valid)))
   `TLPS_ASSERT_IMPL(a_src_excl, busy_ff, from_pri_ff != from_rr_ff)
   `TLPS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `TLPS_ASSERT_IMPL(a_no_take, rsp_tvalid, !req_tready)
endmodule

FILE: tb/tb_two_level_priority_rr_scheduler.sv
// Testbench for the two-level priority / round-robin scheduler: directed table plus random traffic.
`timescale 1ns / 100ps

module tb_two_level_priority_rr_scheduler
   import tlps_pkg::*;
();

   localparam int DEPTH = 16;
   localparam int SETTLE = 3 * (DEPTH + 6) + 10;

   typedef struct {
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [15:0] left;
   } job_type;

   typedef struct {
      logic        op;
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [15:0] burst;
      logic        fixed;
      logic [12:0] want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = '0;

   two_level_priority_rr_scheduler #(.MAX_TASKS(DEPTH)) uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // scheduler shadow state
   job_type     store [DEPTH];
   logic        store_used [DEPTH];
   int          store_cnt;
   job_type     ring [DEPTH];
   int          ring_head, ring_cnt;
   job_type     cur;
   logic        busy, from_store, from_ring;
   logic [7:0]  slice, quantum;

   logic [12:0] pending_results [$];
   int          errors = 0;
   int          row_errors = 0;
   int          hold_off = 0;
   int          hold_req = 0;
   int          hold_seen = 0;
   int          rsp_wait = 0;

   logic [7:0]  quantum_list [5] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd3};

   task automatic clear_shadow();
      for (int i = 0; i < DEPTH; i++) store_used[i] = 1'b0;
      store_cnt = 0; ring_head = 0; ring_cnt = 0;
      cur = '{0, 0, 0}; busy = 0; from_store = 0; from_ring = 0;
      quantum = QUANTUM_RESET; slice = QUANTUM_RESET;
   endtask

   function automatic void ring_push(job_type j);
      if (ring_cnt < DEPTH) begin
         ring[(ring_head + ring_cnt) % DEPTH] = j;
         ring_cnt++;
      end
   endfunction

   function automatic job_type take(int s);
      store_used[s] = 1'b0;
      store_cnt--;
      return store[s];
   endfunction

   function automatic logic [12:0] schedule(logic op, logic [7:0] id, logic [7:0] prio,
                                            logic [15:0] burst);
      logic [1:0] st;
      logic [7:0] rid;
      logic       fin, expd, pre;
      int         b;
      rid = 0; fin = 0; expd = 0; pre = 0; b = -1;
      if (op == OP_ARRIVE) begin
         st = ST_REJECT;
         if (burst != 0 && store_cnt < DEPTH)
            for (int i = 0; i < DEPTH; i++)
               if (!store_used[i] && st == ST_REJECT) begin
                  store[i] = '{id, prio, burst};
                  store_used[i] = 1'b1;
                  store_cnt++;
                  st = ST_ACCEPT;
               end
      end else begin
         for (int i = 0; i < DEPTH; i++)
            if (store_used[i] && (b < 0 || store[i].prio < store[b].prio ||
                (store[i].prio == store[b].prio && store[i].id < store[b].id)))
               b = i;
         if (!busy) begin
            if (b >= 0) begin
               cur = take(b); busy = 1; from_store = 1; slice = quantum;
            end else if (ring_cnt > 0) begin
               cur = ring[ring_head];
               ring_head = (ring_head + 1) % DEPTH;
               ring_cnt--;
               busy = 1; from_ring = 1; slice = quantum;
            end
         end else if (b >= 0) begin
            if (from_store) begin
               if (store[b].prio < cur.prio) begin
                  ring_push(cur); cur = take(b); slice = quantum; pre = 1;
               end
            end else if (from_ring) begin
               ring_push(cur); cur = take(b);
               from_ring = 0; from_store = 1; slice = quantum; pre = 1;
            end
         end
         if (busy) begin
            st = ST_RAN;
            rid = cur.id;
            cur.left = cur.left - 1'b1;
            slice = slice - 1'b1;
            if (cur.left == 0) begin
               fin = 1; busy = 0; from_store = 0; from_ring = 0; slice = quantum;
            end else if (slice == 0) begin
               expd = 1; ring_push(cur); busy = 0; from_store = 0; from_ring = 0;
            end
         end else begin
            st = ST_IDLE;
         end
      end
      return {pre, expd, fin, rid, st};
   endfunction

   task automatic send(logic op, logic [7:0] id, logic [7:0] prio, logic [15:0] burst,
                       logic fixed, logic [12:0] want, int gap);
      logic [12:0] model;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {burst, prio, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model = schedule(op, id, prio, burst);
      if (fixed && model !== want) begin
         $display("%0t table row disagrees: expected %h, model %h", $time, want, model);
         row_errors++;
      end
      pending_results.insert(pending_results.size(), fixed ? want : model);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_quantum(logic [7:0] q);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= q;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      quantum = q;
   endtask

   task automatic random_item(int gap);
      logic op;
      logic [15:0] burst;
      op = ($urandom_range(0, 99) < 55);
      case ($urandom_range(0, 9))
         0: burst = 16'd0;
         1: burst = 16'($urandom);
         default: burst = 16'($urandom_range(1, 12));
      endcase
      send(op, ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
           ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)),
           burst, 1'b0, '0, gap);
   endtask

   function automatic int draw_gap();
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
   endfunction

   // result side
   always @(posedge clock) begin : rsp_side
      int wait_n;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
         hold_off   <= 0;
         hold_seen  <= 0;
      end else begin
         wait_n = (rsp_wait > 0) ? rsp_wait - 1 : 0;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t unexpected result: expected none, actual %h", $time, rsp_tdata);
               errors++;
            end else begin
               if (rsp_tdata !== {3'b000, pending_results[0]}) begin
                  $display("%0t result mismatch: expected %h, actual %h",
                           $time, {3'b000, pending_results[0]}, rsp_tdata);
                  errors++;
               end
               void'(pending_results.pop_front());
            end
            wait_n = $urandom_range(0, 14);
         end
         if (hold_seen != hold_req) begin
            hold_seen  <= hold_req;
            hold_off   <= 400;
            rsp_tready <= 1'b0;
         end else if (hold_off > 0) begin
            hold_off   <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (wait_n == 0);
         end
         rsp_wait <= wait_n;
      end
   end

   // op, id, prio, burst, fixed, expected {pre, exp, fin, id, status}
   row_type directed [20] = '{
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b1, {3'b000, 8'd0,   ST_IDLE}},
      '{OP_ARRIVE, 8'd5,   8'd9,   16'd0,     1'b1, {3'b000, 8'd0,   ST_REJECT}},
      '{OP_ARRIVE, 8'd255, 8'd255, 16'hFFFF,  1'b1, {3'b000, 8'd0,   ST_ACCEPT}},
      '{OP_ARRIVE, 8'd0,   8'd0,   16'd1,     1'b1, {3'b000, 8'd0,   ST_ACCEPT}},
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b1, {3'b001, 8'd0,   ST_RAN}},
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b1, {3'b000, 8'd255, ST_RAN}},
      '{OP_ARRIVE, 8'd7,   8'd3,   16'd2,     1'b0, '0},
      '{OP_ARRIVE, 8'd7,   8'd3,   16'd2,     1'b0, '0},
      '{OP_ARRIVE, 8'd2,   8'd3,   16'd20,    1'b0, '0},
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b0, '0},
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b0, '0},
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b0, '0},
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b0, '0},
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b0, '0},
      '{OP_ARRIVE, 8'd9,   8'd1,   16'd3,     1'b0, '0},
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b0, '0},
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b0, '0},
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b0, '0},
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b0, '0},
      '{OP_TICK,   8'd0,   8'd0,   16'd0,     1'b0, '0}
   };

   initial begin
      clear_shadow();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send(directed[i].op, directed[i].id, directed[i].prio, directed[i].burst,
              directed[i].fixed, directed[i].want, draw_gap());

      // quantum settings including both extremes and the wrapping zero
      foreach (quantum_list[k]) begin
         set_quantum(quantum_list[k]);
         repeat (60) random_item(draw_gap());
      end

      // overflow the store, then back up the result side
      set_quantum(8'd1);
      for (int i = 0; i < 18; i++)
         send(OP_ARRIVE, 8'($urandom), 8'($urandom_range(0, 7)), 16'($urandom_range(1, 4)),
              1'b0, '0, 0);
      repeat (40) send(OP_TICK, 8'd0, 8'd0, 16'd0, 1'b0, '0, 0);
      hold_req <= hold_req + 1;
      repeat (10) random_item(0);

      // wait for the pipeline to empty before continuing
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);

      for (int i = 0; i < 480; i++) begin
         if (i % 160 == 0) set_quantum(8'($urandom_range(1, 6)));
         random_item((i % 100 < 20) ? 0 : draw_gap());
      end
      set_quantum(8'($urandom));
      repeat (40) random_item(draw_gap());

      drain();
      if (errors == 0 && row_errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tlps_pkg.sv
rtl/tlps_store.sv
rtl/tlps_fifo.sv
rtl/two_level_priority_rr_scheduler.sv
tb/tb_two_level_priority_rr_scheduler.sv
